// ===== rtl/spwm_pkg.sv =====
package spwm_pkg;

	localparam int EVENT_SLOTS = 128;
	localparam int TIME_BITS   = 31;
	localparam int IDX_BITS    = $clog2(EVENT_SLOTS);
	localparam int CNT_BITS    = $clog2(EVENT_SLOTS + 1);
	localparam int ADDR_BITS   = IDX_BITS + 1;
	localparam int MEM_DEPTH   = 2 * EVENT_SLOTS;
	localparam int MARGIN_BITS = 4;
	localparam int REQ_BITS    = 3;
	localparam int IN_FIELDS_W = 111;
	localparam int IN_TDATA_W  = 112;
	localparam int OUT_TDATA_W = 112;

	localparam logic [MARGIN_BITS-1:0] MARGIN_RESET = 4'd4;

	localparam logic [REQ_BITS-1:0] REQ_TICK  = 3'd0;
	localparam logic [REQ_BITS-1:0] REQ_WRITE = 3'd1;
	localparam logic [REQ_BITS-1:0] REQ_STAGE = 3'd2;
	localparam logic [REQ_BITS-1:0] REQ_START = 3'd3;
	localparam logic [REQ_BITS-1:0] REQ_STOP  = 3'd4;

	typedef struct packed {
		logic                 level;
		logic [1:0]           phase;
		logic [TIME_BITS-1:0] tstamp;
	} edge_t;

	localparam int EDGE_W = $bits(edge_t);

	typedef struct packed {
		logic                 done;
		logic [TIME_BITS-1:0] rem;
	} remdr_res_t;

endpackage

// ===== rtl/spwm_ram.sv =====
module spwm_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/spwm_remdr.sv =====
module spwm_remdr import spwm_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [TIME_BITS-1:0] dividend,
	input  logic [TIME_BITS:0]   divisor,
	output remdr_res_t           res
);

	localparam int STEP_BITS = $clog2(TIME_BITS);

	logic                 busy_q;
	logic                 done_q;
	logic [STEP_BITS-1:0] step_q;
	logic [TIME_BITS:0]   rem_q;
	logic [TIME_BITS-1:0] dvd_q;
	logic [TIME_BITS:0]   dvs_q;
	logic [TIME_BITS+1:0] shifted;
	logic [TIME_BITS+1:0] diff;
	logic                 fits;

	// Restoring remainder, one dividend bit per cycle, most significant first.
	always_comb begin
		shifted = {rem_q, dvd_q[TIME_BITS-1]};
		diff    = shifted - {1'b0, dvs_q};
		fits    = shifted >= {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				step_q <= STEP_BITS'(TIME_BITS - 1);
			end else if (busy_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			rem_q <= '0;
			dvd_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[TIME_BITS:0] : shifted[TIME_BITS:0];
			dvd_q <= {dvd_q[TIME_BITS-2:0], 1'b0};
		end
	end

	assign res.done = done_q;
	assign res.rem  = rem_q[TIME_BITS-1:0];

endmodule

// ===== rtl/she_pwm_event_player.sv =====
// Three-phase edge-list player with two ping-pong buffers in one event RAM.
// Input beats on s_axis carry a request (tuser) and its operands (tdata):
// tick, write event, stage pattern, start and stop. Every request gives
// exactly one result beat on m_axis with the forced phase levels, the
// counter position, the item flags and the running tallies.
// The due margin is to be written through cfg_we/cfg_wdata only while the block
// is idle; the block itself does not enforce this. Steps per request: write,
// stage, stop and a stopped tick go from execution to the result; a running
// tick then drains the edges that are due, and the edge drain reads one RAM
// entry per cycle. A start uses a 31-step remainder unit to take the count
// modulo period+1, then scans the RAM once.
// Results are registered; the next beat is accepted while a result waits,
// but that item is held at its end until the receiver has taken the
// earlier result. Reset stops the player, clears both buffer lengths and
// periods, the tallies and the margin (back to 4); the RAM is not cleared.
module she_pwm_event_player import spwm_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [MARGIN_BITS-1:0]  cfg_wdata,
	input  logic                    s_axis_tvalid,
	output logic                    s_axis_tready,
	// event_index, event_time, event_phase, event_level, pattern_period,
	// pattern_length, start_count
	input  logic [IN_TDATA_W-1:0]   s_axis_tdata,
	// req_type
	input  logic [REQ_BITS-1:0]     s_axis_tuser,
	output logic                    m_axis_tvalid,
	input  logic                    m_axis_tready,
	// level_u, level_v, level_w, outputs_forced, start_ok, wrapped,
	// edges_applied, timer_value, cycle_total, edge_total
	output logic [OUT_TDATA_W-1:0]  m_axis_tdata
);

	typedef enum logic [6:0] {
		ST_IDLE  = 7'b0000001,
		ST_EXEC  = 7'b0000010,
		ST_DRAIN = 7'b0000100,
		ST_DIV   = 7'b0001000,
		ST_SCAN  = 7'b0010000,
		ST_DONE  = 7'b0100000,
		ST_SPARE = 7'b1000000
	} state_t;

	state_t                  state_q;
	logic [REQ_BITS-1:0]     req_q;
	logic [IN_FIELDS_W-1:0]  item_q;
	logic [MARGIN_BITS-1:0]  margin_q;
	logic [TIME_BITS-1:0]    period_q [2];
	logic [CNT_BITS-1:0]     length_q [2];
	logic                    active_q;
	logic                    pend_valid_q;
	logic                    pend_buf_q;
	logic [CNT_BITS-1:0]     cursor_q;
	logic [TIME_BITS-1:0]    counter_q;
	logic                    running_q;
	logic [2:0]              levels_q;
	logic [31:0]             wrap_tally_q;
	logic [31:0]             edge_tally_q;
	logic [CNT_BITS-1:0]     applied_q;
	logic                    start_ok_q;
	logic                    wrapped_q;
	logic [TIME_BITS:0]      due_q;
	logic [TIME_BITS-1:0]    start_pos_q;
	logic [CNT_BITS-1:0]     scan_q;
	logic                    stop_q;
	logic [2:0]              seen_q;
	logic [2:0]              last_q;
	logic [2:0]              found_q;
	logic [2:0]              fnd_q;
	logic                    m_valid_q;
	logic [OUT_TDATA_W-1:0]  m_data_q;

	logic [IDX_BITS-1:0]     it_idx;
	logic [TIME_BITS-1:0]    it_time;
	logic [1:0]              it_phase;
	logic                    it_level;
	logic [TIME_BITS-1:0]    it_period;
	logic [7:0]              it_len;
	logic [TIME_BITS-1:0]    it_start;
	logic [CNT_BITS-1:0]     len_sat;

	logic                    wrap_now;
	logic                    buf_next;
	logic [TIME_BITS-1:0]    cnt_next;
	logic [CNT_BITS-1:0]     cursor_next;
	logic                    start_buf;
	logic                    rem_go;
	logic [TIME_BITS:0]      span;
	remdr_res_t              rem_res;

	logic                    wr_en;
	logic [ADDR_BITS-1:0]    waddr;
	logic [ADDR_BITS-1:0]    raddr;
	logic [IDX_BITS-1:0]     rd_idx;
	logic                    rd_buf;
	logic [EDGE_W-1:0]       rdata;
	edge_t                   rd_edge;
	logic                    drain_hit;
	logic [2:0]              drive_mask;
	logic [CNT_BITS-1:0]     cursor_inc;
	logic [CNT_BITS-1:0]     scan_inc;
	logic                    scan_last;
	logic                    scan_le;
	logic [2:0]              ph_match;
	logic [2:0]              seen_n;
	logic [2:0]              last_n;
	logic [2:0]              found_n;
	logic [2:0]              fnd_n;
	logic [2:0]              lv_final;
	logic                    accept;
	logic                    out_load;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_load = (state_q == ST_DONE) && (!m_valid_q || m_axis_tready);

	assign it_idx    = item_q[6:0];
	assign it_time   = item_q[37:7];
	assign it_phase  = item_q[39:38];
	assign it_level  = item_q[40];
	assign it_period = item_q[71:41];
	assign it_len    = item_q[79:72];
	assign it_start  = item_q[110:80];

	always_comb begin
		len_sat = (it_len > 8'(EVENT_SLOTS)) ? CNT_BITS'(EVENT_SLOTS) : CNT_BITS'(it_len);

		wrap_now    = counter_q >= period_q[active_q];
		buf_next    = (wrap_now && pend_valid_q) ? pend_buf_q : active_q;
		cnt_next    = wrap_now ? '0 : counter_q + 1'b1;
		cursor_next = wrap_now ? '0 : cursor_q;

		start_buf = pend_valid_q ? pend_buf_q : active_q;
		span      = {1'b0, period_q[start_buf]} + 1'b1;
		rem_go    = (state_q == ST_EXEC) && (req_q == REQ_START) && !running_q &&
		            (length_q[start_buf] != '0);

		wr_en = (state_q == ST_EXEC) && (req_q == REQ_WRITE) &&
		        ({1'b0, it_idx} < (IDX_BITS + 1)'(EVENT_SLOTS));
		waddr = {~active_q, it_idx};
	end

	assign cursor_inc = cursor_q + 1'b1;
	assign scan_inc   = scan_q + 1'b1;

	// The read issued in one cycle is the entry examined in the next one.
	always_comb begin
		rd_buf = active_q;
		case (state_q)
			ST_EXEC: begin
				rd_buf = buf_next;
				rd_idx = cursor_next[IDX_BITS-1:0];
			end
			ST_DRAIN: rd_idx = cursor_inc[IDX_BITS-1:0];
			ST_SCAN:  rd_idx = scan_inc[IDX_BITS-1:0];
			default:  rd_idx = '0;
		endcase
		raddr = {rd_buf, rd_idx};
	end

	spwm_ram #(
		.WIDTH(EDGE_W),
		.DEPTH(MEM_DEPTH)
	) u_event_ram (
		.clk  (clk),
		.we   (wr_en),
		.waddr(waddr),
		.wdata({it_level, it_phase, it_time}),
		.raddr(raddr),
		.rdata(rdata)
	);

	spwm_remdr u_remdr (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (rem_go),
		.dividend(it_start),
		.divisor (span),
		.res     (rem_res)
	);

	always_comb begin
		rd_edge    = edge_t'(rdata);
		drain_hit  = (cursor_q < length_q[active_q]) && ({1'b0, rd_edge.tstamp} <= due_q);
		drive_mask = 3'b001 << rd_edge.phase;

		scan_le   = rd_edge.tstamp <= start_pos_q;
		scan_last = scan_inc == length_q[active_q];
		ph_match  = drive_mask;
		seen_n    = seen_q | ph_match;
		last_n    = (last_q & ~ph_match) | (ph_match & {3{rd_edge.level}});
		found_n   = found_q | (ph_match & {3{scan_le}});
		fnd_n     = (fnd_q & ~(ph_match & {3{scan_le}})) |
		            (ph_match & {3{scan_le & rd_edge.level}});
		// A phase with no edge at or before the start takes its last edge,
		// and a phase with no edge at all starts high.
		lv_final  = (found_n & fnd_n) | (~found_n & seen_n & last_n) | (~found_n & ~seen_n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			margin_q     <= MARGIN_RESET;
			period_q[0]  <= '0;
			period_q[1]  <= '0;
			length_q[0]  <= '0;
			length_q[1]  <= '0;
			active_q     <= 1'b0;
			pend_valid_q <= 1'b0;
			pend_buf_q   <= 1'b0;
			cursor_q     <= '0;
			counter_q    <= '0;
			running_q    <= 1'b0;
			levels_q     <= '0;
			wrap_tally_q <= '0;
			edge_tally_q <= '0;
			applied_q    <= '0;
			start_ok_q   <= 1'b0;
			wrapped_q    <= 1'b0;
			scan_q       <= '0;
			stop_q       <= 1'b0;
			seen_q       <= '0;
			last_q       <= '0;
			found_q      <= '0;
			fnd_q        <= '0;
			m_valid_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				margin_q <= cfg_wdata;
			end
			if (out_load) begin
				m_valid_q <= 1'b1;
			end else if (m_valid_q && m_axis_tready) begin
				m_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						start_ok_q <= 1'b0;
						wrapped_q  <= 1'b0;
						applied_q  <= '0;
						state_q    <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					case (req_q)
						REQ_TICK: begin
							if (running_q) begin
								counter_q <= cnt_next;
								cursor_q  <= cursor_next;
								active_q  <= buf_next;
								if (wrap_now) begin
									wrap_tally_q <= wrap_tally_q + 1'b1;
									pend_valid_q <= 1'b0;
									wrapped_q    <= 1'b1;
								end
								state_q <= ST_DRAIN;
							end else begin
								state_q <= ST_DONE;
							end
						end
						REQ_STAGE: begin
							period_q[~active_q] <= it_period;
							length_q[~active_q] <= len_sat;
							pend_valid_q        <= 1'b1;
							pend_buf_q          <= ~active_q;
							state_q             <= ST_DONE;
						end
						REQ_START: begin
							if (running_q) begin
								start_ok_q <= 1'b1;
								state_q    <= ST_DONE;
							end else begin
								active_q     <= start_buf;
								pend_valid_q <= 1'b0;
								if (length_q[start_buf] != '0) begin
									state_q <= ST_DIV;
								end else begin
									state_q <= ST_DONE;
								end
							end
						end
						REQ_STOP: begin
							running_q <= 1'b0;
							state_q   <= ST_DONE;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_DRAIN: begin
					if (drain_hit) begin
						levels_q     <= (levels_q & ~drive_mask) |
						                (drive_mask & {3{rd_edge.level}});
						cursor_q     <= cursor_inc;
						edge_tally_q <= edge_tally_q + 1'b1;
						applied_q    <= applied_q + 1'b1;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DIV: begin
					if (rem_res.done) begin
						scan_q   <= '0;
						cursor_q <= '0;
						stop_q   <= 1'b0;
						seen_q   <= '0;
						found_q  <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					seen_q  <= seen_n;
					last_q  <= last_n;
					found_q <= found_n;
					fnd_q   <= fnd_n;
					scan_q  <= scan_inc;
					// The cursor stops at the first edge that lies after the start.
					if (!stop_q) begin
						if (scan_le) begin
							cursor_q <= scan_inc;
						end else begin
							stop_q <= 1'b1;
						end
					end
					if (scan_last) begin
						levels_q   <= lv_final;
						counter_q  <= start_pos_q;
						running_q  <= 1'b1;
						start_ok_q <= 1'b1;
						state_q    <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q  <= s_axis_tuser;
			item_q <= s_axis_tdata[IN_FIELDS_W-1:0];
		end
		if (state_q == ST_EXEC) begin
			due_q <= {1'b0, cnt_next} + (TIME_BITS + 1)'(margin_q);
		end
		if (state_q == ST_DIV && rem_res.done) begin
			start_pos_q <= rem_res.rem;
		end
		if (out_load) begin
			m_data_q <= {3'b000, edge_tally_q, wrap_tally_q, counter_q, applied_q,
			             wrapped_q, start_ok_q, running_q, levels_q & {3{running_q}}};
		end
	end

	assign s_axis_tready = state_q == ST_IDLE;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;

	a_cursor_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && running_q) |-> (cursor_q <= length_q[active_q]))
		else $error("edge cursor beyond the active pattern");

	a_stopped_tick_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && req_q == REQ_TICK && !running_q) |=> $stable(counter_q))
		else $error("counter moved on a tick while stopped");

	a_wrap_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[5]) |-> (m_axis_tdata[44:14] == '0))
		else $error("wrap reported with a nonzero counter");

	a_drain_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		applied_q <= CNT_BITS'(EVENT_SLOTS))
		else $error("more edges applied than a pattern can hold");

endmodule

// ===== dv/she_pwm_event_player_tb.sv =====
module she_pwm_event_player_tb;
	import spwm_pkg::*;

	localparam int CYCLE_LIMIT = 1_500_000;
	localparam int ITEM_TARGET = 1750;
	localparam int PHASES      = 8;
	localparam int HOLD_CYCLES = 300;

	// Request codes that the block must treat as no-ops.
	localparam logic [REQ_BITS-1:0] REQ_SPARE_LO = 3'd5;
	localparam logic [REQ_BITS-1:0] REQ_SPARE_HI = 3'd7;

	localparam logic [1:0] PH_U    = 2'd0;
	localparam logic [1:0] PH_V    = 2'd1;
	localparam logic [1:0] PH_W    = 2'd2;
	localparam logic [1:0] PH_NONE = 2'd3;

	localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

	typedef struct {
		logic [REQ_BITS-1:0]  req;
		logic [IDX_BITS-1:0]  idx;
		logic [TIME_BITS-1:0] etime;
		logic [1:0]           ph;
		logic                 lvl;
		logic [TIME_BITS-1:0] period;
		logic [7:0]           len;
		logic [TIME_BITS-1:0] start;
	} player_req_t;

	typedef struct packed {
		logic [2:0]           pad;
		logic [31:0]          edge_total;
		logic [31:0]          cycle_total;
		logic [TIME_BITS-1:0] timer_value;
		logic [7:0]           edges_applied;
		logic                 wrapped;
		logic                 start_ok;
		logic                 outputs_forced;
		logic                 level_w;
		logic                 level_v;
		logic                 level_u;
	} player_report_t;

	class play_scoreboard;
		bit [TIME_BITS-1:0]   ev_time  [2][EVENT_SLOTS];
		bit [1:0]             ev_phase [2][EVENT_SLOTS];
		bit                   ev_level [2][EVENT_SLOTS];
		bit [EVENT_SLOTS-1:0] written  [2];
		bit [TIME_BITS-1:0]   period   [2];
		bit [7:0]             length   [2];
		bit                   active;
		bit                   pend_valid;
		bit                   pend_buf;
		bit                   running;
		bit [7:0]             cursor;
		bit [TIME_BITS-1:0]   counter;
		bit [2:0]             levels;
		bit [31:0]            wrap_tally;
		bit [31:0]            edge_tally;
		bit [MARGIN_BITS-1:0] margin;
		player_report_t       awaited[$];
		int                   failures;

		function new();
			margin = MARGIN_RESET;
			failures = 0;
		endfunction

		// Number of slots written without a hole from slot zero up.
		function int written_run(bit b);
			int n;
			n = 0;
			while (n < EVENT_SLOTS && written[b][n])
				n++;
			return n;
		endfunction

		function void take_pending();
			if (pend_valid) begin
				active = pend_buf;
				pend_valid = 1'b0;
			end
		endfunction

		function void drive_phase(bit [1:0] ph, bit lv);
			if (ph != PH_NONE)
				levels[ph] = lv;
		endfunction

		function void note_request(player_req_t r);
			player_report_t          rep;
			bit                      nb;
			bit [TIME_BITS+1:0]      due;
			bit [31:0]               span;
			bit [TIME_BITS-1:0]      st;
			bit                      lv;
			bit                      found;
			int                      n;
			int                      applied;
			rep = '0;
			applied = 0;
			nb = ~active;
			case (r.req)
				REQ_TICK: begin
					if (running) begin
						if (counter >= period[active]) begin
							counter = '0;
							cursor = '0;
							wrap_tally++;
							take_pending();
							rep.wrapped = 1'b1;
						end else begin
							counter++;
						end
						due = {2'b00, counter} + margin;
						while (cursor < length[active] && ev_time[active][cursor] <= due) begin
							drive_phase(ev_phase[active][cursor], ev_level[active][cursor]);
							cursor++;
							edge_tally++;
							applied++;
						end
					end
				end
				REQ_WRITE: begin
					ev_time[nb][r.idx] = r.etime;
					ev_phase[nb][r.idx] = r.ph;
					ev_level[nb][r.idx] = r.lvl;
					written[nb][r.idx] = 1'b1;
				end
				REQ_STAGE: begin
					period[nb] = r.period;
					length[nb] = (r.len > EVENT_SLOTS) ? 8'(EVENT_SLOTS) : r.len;
					pend_valid = 1'b1;
					pend_buf = nb;
				end
				REQ_START: begin
					if (running) begin
						rep.start_ok = 1'b1;
					end else begin
						take_pending();
						n = length[active];
						if (n != 0) begin
							span = {1'b0, period[active]} + 32'd1;
							st = TIME_BITS'(32'(r.start) % span);
							// A phase takes its last edge at or before the start point,
							// else its last edge in the list, else it goes high.
							for (int p = 0; p < 3; p++) begin
								found = 1'b0;
								lv = 1'b1;
								for (int i = 0; i < n; i++)
									if (ev_phase[active][i] == p && ev_time[active][i] <= st) begin
										found = 1'b1;
										lv = ev_level[active][i];
									end
								if (!found)
									for (int i = 0; i < n; i++)
										if (ev_phase[active][i] == p)
											lv = ev_level[active][i];
								drive_phase(2'(p), lv);
							end
							cursor = '0;
							while (cursor < length[active] && ev_time[active][cursor] <= st)
								cursor++;
							counter = st;
							running = 1'b1;
							rep.start_ok = 1'b1;
						end
					end
				end
				REQ_STOP: begin
					running = 1'b0;
				end
				default: begin
				end
			endcase
			rep.level_u = running & levels[0];
			rep.level_v = running & levels[1];
			rep.level_w = running & levels[2];
			rep.outputs_forced = running;
			rep.edges_applied = 8'(applied);
			rep.timer_value = counter;
			rep.cycle_total = wrap_tally;
			rep.edge_total = edge_tally;
			awaited.push_back(rep);
		endfunction

		function void compare(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				failures++;
			end
		endfunction

		function void check_report(logic [OUT_TDATA_W-1:0] beat);
			player_report_t got;
			player_report_t want;
			got = beat;
			if (awaited.size() == 0) begin
				$error("result beat with no request outstanding: %h", beat);
				failures++;
			end else begin
				want = awaited.pop_front();
				compare("level_u", want.level_u, got.level_u);
				compare("level_v", want.level_v, got.level_v);
				compare("level_w", want.level_w, got.level_w);
				compare("outputs_forced", want.outputs_forced, got.outputs_forced);
				compare("start_ok", want.start_ok, got.start_ok);
				compare("wrapped", want.wrapped, got.wrapped);
				compare("edges_applied", want.edges_applied, got.edges_applied);
				compare("timer_value", want.timer_value, got.timer_value);
				compare("cycle_total", want.cycle_total, got.cycle_total);
				compare("edge_total", want.edge_total, got.edge_total);
			end
		endfunction
	endclass

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [MARGIN_BITS-1:0] cfg_wdata;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata;
	logic [REQ_BITS-1:0]    s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;
	int items_sent = 0;
	int cycles = 0;

	play_scoreboard sb = new();

	she_pwm_event_player dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > CYCLE_LIMIT) begin
				$display("[she_pwm_event_player] ERROR");
				$finish;
			end
		end
	end

	// Result side: check each beat at the rising edge, pick the next ready level
	// at the falling edge. A long hold-off lets the block back up into its input.
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid === 1'b1 && m_axis_tready)
				sb.check_report(m_axis_tdata);
			@(negedge clk);
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	function automatic player_req_t noise_request(logic [REQ_BITS-1:0] code);
		player_req_t r;
		r.req = code;
		r.idx = IDX_BITS'($urandom);
		r.etime = TIME_BITS'($urandom);
		r.ph = 2'($urandom);
		r.lvl = 1'($urandom);
		r.period = TIME_BITS'($urandom);
		r.len = 8'($urandom);
		r.start = TIME_BITS'($urandom);
		return r;
	endfunction

	task automatic send_item(player_req_t r);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= r.req;
		s_axis_tdata <= {1'b0, r.start, r.len, r.period, r.lvl, r.ph, r.etime, r.idx};
		@(posedge clk);
		while (s_axis_tready !== 1'b1)
			@(posedge clk);
		sb.note_request(r);
		items_sent++;
	endtask

	task automatic req_plain(logic [REQ_BITS-1:0] code);
		send_item(noise_request(code));
	endtask

	task automatic req_write(int idx, logic [TIME_BITS-1:0] t, logic [1:0] ph, logic lv);
		player_req_t r;
		r = noise_request(REQ_WRITE);
		r.idx = IDX_BITS'(idx);
		r.etime = t;
		r.ph = ph;
		r.lvl = lv;
		send_item(r);
	endtask

	// The staged length never reaches past the slots already written (a length over
	// a full list is clamped by the player), so the player never reads an empty slot.
	task automatic req_stage(logic [TIME_BITS-1:0] per, int len);
		player_req_t r;
		int          usable;
		usable = sb.written_run(~sb.active);
		if (len > usable && usable < EVENT_SLOTS)
			len = usable;
		r = noise_request(REQ_STAGE);
		r.period = per;
		r.len = 8'(len);
		send_item(r);
	endtask

	task automatic req_start(logic [TIME_BITS-1:0] cnt);
		player_req_t r;
		r = noise_request(REQ_START);
		r.start = cnt;
		send_item(r);
	endtask

	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (sb.awaited.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// One pattern: fill the free buffer, stage it, start if stopped, then run
	// ticks with the odd stop, restart or stray write mixed in.
	task automatic play_session();
		int                   n;
		int                   per;
		int                   k;
		int                   roll;
		int                   gap;
		int                   len;
		bit                   shuffled;
		logic [TIME_BITS-1:0] t;
		logic [TIME_BITS-1:0] cnt;
		roll = $urandom_range(99);
		if (roll < 70)
			per = $urandom_range(4, 40);
		else if (roll < 90)
			per = $urandom_range(41, 400);
		else
			per = $urandom_range(0, 3);
		roll = $urandom_range(99);
		if (roll < 8)
			n = 0;
		else if (roll < 83)
			n = $urandom_range(1, 10);
		else if (roll < 97)
			n = $urandom_range(11, 40);
		else
			n = EVENT_SLOTS;
		shuffled = ($urandom_range(99) < 8);
		gap = (2 * per) / (n + 1) + 1;
		t = TIME_BITS'($urandom_range(0, 3));
		for (int i = 0; i < n; i++) begin
			if (shuffled)
				t = TIME_BITS'($urandom_range(0, per + 2));
			req_write(i, t, ($urandom_range(9) == 0) ? PH_NONE : 2'($urandom_range(0, 2)),
				1'($urandom));
			t = t + TIME_BITS'($urandom_range(0, gap));
		end
		len = n;
		if (n == EVENT_SLOTS && $urandom_range(1) == 1)
			len = $urandom_range(EVENT_SLOTS + 1, 255);
		req_stage(TIME_BITS'(per), len);
		if (!sb.running) begin
			roll = $urandom_range(99);
			if (roll < 50)
				cnt = TIME_BITS'($urandom_range(0, per));
			else if (roll < 80)
				cnt = TIME_BITS'($urandom);
			else
				cnt = '0;
			req_start(cnt);
		end
		k = $urandom_range(per + 2, 2 * per + 8);
		if (k > 150)
			k = 150;
		for (int i = 0; i < k; i++) begin
			roll = $urandom_range(99);
			if (roll < 2)
				req_plain(REQ_STOP);
			else if (roll < 4)
				req_start(TIME_BITS'($urandom));
			else if (roll < 6)
				req_write($urandom_range(0, EVENT_SLOTS - 1), TIME_BITS'($urandom),
					2'($urandom), 1'($urandom));
			else
				req_plain(REQ_TICK);
		end
		if ($urandom_range(3) == 0)
			req_plain(REQ_STOP);
	endtask

	initial begin
		int                     goal;
		logic [MARGIN_BITS-1:0] m;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = REQ_TICK;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Stopped block: ticks and stops do nothing, an empty start is refused,
		// unused request codes only report.
		req_plain(REQ_TICK);
		req_plain(REQ_STOP);
		req_start('0);
		req_plain(REQ_SPARE_LO);
		req_plain(REQ_SPARE_HI);
		req_stage('0, 0);
		req_start(31'd3);

		// Widest period and times, an edge that drives no phase, the top slot.
		req_write(0, '0, PH_U, 1'b0);
		req_write(1, 31'd2, PH_V, 1'b1);
		req_write(2, 31'd3, PH_NONE, 1'b1);
		req_write(3, TIME_MAX, PH_W, 1'b0);
		req_write(EVENT_SLOTS - 1, TIME_MAX, PH_NONE, 1'b1);
		req_stage(TIME_MAX, 4);
		req_start(TIME_MAX);
		req_plain(REQ_TICK);
		req_plain(REQ_TICK);
		req_start(31'd9);
		req_plain(REQ_STOP);
		req_plain(REQ_TICK);

		// Only phase W has an edge, so U and V start high; period zero wraps
		// on every tick.
		req_write(0, 31'd5, PH_W, 1'b1);
		req_stage('0, 1);
		req_start('0);
		req_plain(REQ_TICK);
		req_plain(REQ_TICK);

		for (int ph = 0; ph < PHASES; ph++) begin
			settle();
			case (ph % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct = 63;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct = 63;
				end
				default: begin
					send_idle_pct = 19;
					recv_stall_pct = 19;
				end
			endcase
			if (ph > 0) begin
				if (ph == 1)
					m = '0;
				else if (ph == 2)
					m = '1;
				else
					m = MARGIN_BITS'($urandom_range(0, 15));
				@(negedge clk);
				cfg_we <= 1'b1;
				cfg_wdata <= m;
				@(negedge clk);
				cfg_we <= 1'b0;
				sb.margin = m;
			end
			if (ph == 4)
				hold_left = HOLD_CYCLES;
			goal = (ph + 1) * ITEM_TARGET / PHASES;
			while (items_sent < goal)
				play_session();
		end

		settle();
		repeat (20) @(negedge clk);
		if (sb.failures == 0)
			$display("[she_pwm_event_player] OK");
		else
			$display("[she_pwm_event_player] ERROR");
		$finish;
	end

endmodule
